// File: rtl/bfm_pkg.sv
package bfm_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int CHANNELS  = 3;

    localparam int NCH       = 3;
    localparam int CH_W      = 8;
    localparam int PIX_W     = NCH * CH_W;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 16;
    localparam int ROW_W     = 16;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // nine 8-bit values sum to at most 2295
    localparam int COLSUM_W  = 10;
    localparam int SUM_W     = 12;

    // floor(s / 9) == (s * 7282) >> 16 for every s below 32768
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(7282);

    localparam logic [WIDTH_W-1:0]  WIDTH_MIN    = WIDTH_W'(2);
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX    = WIDTH_W'(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN   = HEIGHT_W'(2);
    localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(768);

    typedef logic [PIX_W-1:0] pix_t;

    typedef struct packed {
        pix_t top;
        pix_t mid;
        pix_t bot;
    } col_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_MODE   = 2'd2
    } cfg_reg_t;

    // bit 1: centre on the last row, bit 0: centre on the last column
    typedef enum logic [1:0] {
        JOB_UPPER_LEFT = 2'd0,
        JOB_UPPER_EDGE = 2'd1,
        JOB_LAST_LEFT  = 2'd2,
        JOB_LAST_EDGE  = 2'd3
    } job_t;

    typedef logic [3:0] job_mask_t;

endpackage

// File: rtl/bfm_col_cell.sv
module bfm_col_cell (
    input  logic           clk,
    input  logic           shift,
    input  bfm_pkg::col_t  col_in,
    output bfm_pkg::col_t  col_out
);
    import bfm_pkg::*;

    col_t col_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

// File: rtl/bfm_line_buf.sv
module bfm_line_buf (
    input  logic                      clk,
    input  logic                      rd_en,
    input  logic [bfm_pkg::COL_W-1:0] rd_addr,
    input  logic                      wr_en,
    input  logic [bfm_pkg::COL_W-1:0] wr_addr,
    input  bfm_pkg::pix_t             upper_wdata,
    input  bfm_pkg::pix_t             middle_wdata,
    output bfm_pkg::pix_t             upper_rdata,
    output bfm_pkg::pix_t             middle_rdata
);
    import bfm_pkg::*;

    pix_t upper_mem  [0:MAX_WIDTH-1];
    pix_t middle_mem [0:MAX_WIDTH-1];
    pix_t upper_rdata_reg;
    pix_t middle_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            upper_mem[wr_addr]  <= upper_wdata;
            middle_mem[wr_addr] <= middle_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            upper_rdata_reg  <= upper_mem[rd_addr];
            middle_rdata_reg <= middle_mem[rd_addr];
        end
    end

    assign upper_rdata  = upper_rdata_reg;
    assign middle_rdata = middle_rdata_reg;

endmodule

// File: rtl/bfm_mean.sv
module bfm_mean (
    input  logic [bfm_pkg::SUM_W-1:0] sum,
    output logic [bfm_pkg::CH_W-1:0]  mean
);
    import bfm_pkg::*;

    logic [PROD_W-1:0] prod;

    // divide by nine through the reciprocal
    assign prod = PROD_W'(sum) * PROD_W'(RECIP);
    assign mean = prod[RECIP_SHIFT +: CH_W];

endmodule

// File: rtl/box_filter_3x3_mean_top.sv
// 3x3 box mean filter on a raster-order pixel stream, gray or RGB by mode_reg.
// Each result is the truncated per-channel mean of the nine original pixels around
// one centre, with edge pixels replicated. Unless the output stalls, the single
// result path moves one word per clock, so one pixel is taken per clock while it
// causes at most one result; a pixel that causes k results (two at the end of a
// row, two per pixel on the last row and four at the last column of the last row)
// holds the input until its last result is taken. Results pass the item, sum and
// output registers. The last two rows' results come interleaved. Line stores need
// no clearing after reset. Writing width, height or mode restarts the frame.
module box_filter_3x3_mean_top (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [bfm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bfm_pkg::CFG_W-1:0]     cfg_data,

    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bfm_pkg::CH_W-1:0]      red_or_gray,
    input  logic [bfm_pkg::CH_W-1:0]      green_in,
    input  logic [bfm_pkg::CH_W-1:0]      blue_in,

    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bfm_pkg::CH_W-1:0]      out_red_or_gray,
    output logic [bfm_pkg::CH_W-1:0]      out_green,
    output logic [bfm_pkg::CH_W-1:0]      out_blue,
    output logic [bfm_pkg::ROW_W-1:0]     out_row,
    output logic [bfm_pkg::COL_W-1:0]     out_column,
    output logic                          last_of_run,
    output logic                          last_of_frame
);
    import bfm_pkg::*;

    // configuration
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                mode_reg;
    logic                cfg_hit;
    logic [WIDTH_W-1:0]  w_clamped;
    logic [HEIGHT_W-1:0] h_clamped;
    logic [COL_W-1:0]    last_col;
    logic [ROW_W-1:0]    last_row;

    // position counters
    logic [COL_W-1:0]    col_cnt_reg;
    logic [COL_W-1:0]    col_cnt_next;
    logic [ROW_W-1:0]    row_cnt_reg;
    logic [ROW_W-1:0]    row_cnt_next;

    logic                in_accept;
    pix_t                in_pix;
    job_mask_t           in_mask;

    // item stage
    logic                b_valid_reg;
    logic                b_valid_next;
    job_mask_t           b_mask_reg;
    job_mask_t           b_mask_next;
    job_mask_t           b_mask_rest;
    logic [COL_W-1:0]    b_col_reg;
    logic [ROW_W-1:0]    b_row_reg;
    pix_t                b_pix_reg;
    logic                b_emit;
    logic                b_retire;
    job_t                b_job;
    logic                b_top_is_mid;
    logic [SUM_W-1:0]    b_sum [NCH];

    pix_t                upper_rd;
    pix_t                middle_rd;
    col_t                cur_col;
    col_t                win0;
    col_t                win1;
    col_t                left_col;
    logic [COLSUM_W-1:0] ls;
    logic [COLSUM_W-1:0] ms;
    logic [COLSUM_W-1:0] rs;

    // sum stage
    logic                c_valid_reg;
    logic                c_valid_next;
    logic                c_ready;
    logic [SUM_W-1:0]    c_sum_reg [NCH];
    logic [ROW_W-1:0]    c_row_reg;
    logic [COL_W-1:0]    c_col_reg;
    logic                c_lrun_reg;
    logic                c_lframe_reg;
    logic [CH_W-1:0]     c_mean [NCH];

    // output stage
    logic                d_valid_reg;
    logic                d_valid_next;
    logic                d_ready;
    logic                d_load;
    logic [CH_W-1:0]     d_mean_reg [NCH];
    logic [ROW_W-1:0]    d_row_reg;
    logic [COL_W-1:0]    d_col_reg;
    logic                d_lrun_reg;
    logic                d_lframe_reg;

    function automatic logic [COLSUM_W-1:0] col_sum(input col_t x, input int ch,
                                                    input logic last_row_job,
                                                    input logic top_is_mid);
        logic [COLSUM_W-1:0] e0;
        logic [COLSUM_W-1:0] e1;
        logic [COLSUM_W-1:0] e2;
        e0 = COLSUM_W'(x.top[ch*CH_W +: CH_W]);
        e1 = COLSUM_W'(x.mid[ch*CH_W +: CH_W]);
        e2 = COLSUM_W'(x.bot[ch*CH_W +: CH_W]);
        // on the last row the bottom neighbour replicates the centre row
        if (last_row_job)
        begin
            col_sum = e1 + (e2 << 1);
        end
        else
        begin
            col_sum = (top_is_mid ? e1 : e0) + e1 + e2;
        end
    endfunction

    // ---------------------------------------------------------------- config

    always_comb
    begin
        cfg_hit = 1'b0;
        if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  cfg_hit = 1'b1;
                REG_HEIGHT: cfg_hit = 1'b1;
                REG_MODE:   cfg_hit = 1'b1;
                default:    cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            mode_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_WIDTH:  width_reg  <= cfg_data[WIDTH_W-1:0];
                REG_HEIGHT: height_reg <= cfg_data[HEIGHT_W-1:0];
                REG_MODE:   mode_reg   <= cfg_data[0];
                default:    mode_reg   <= mode_reg;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < WIDTH_MIN)
        begin
            w_clamped = WIDTH_MIN;
        end
        else if (width_reg > WIDTH_MAX)
        begin
            w_clamped = WIDTH_MAX;
        end
        else
        begin
            w_clamped = width_reg;
        end
        h_clamped = (height_reg < HEIGHT_MIN) ? HEIGHT_MIN : height_reg;
    end

    assign last_col = COL_W'(w_clamped - WIDTH_W'(1));
    assign last_row = ROW_W'(h_clamped - HEIGHT_W'(1));

    // ------------------------------------------------------------ input side

    assign in_accept = in_valid && !in_stall;
    assign in_pix    = {mode_reg ? blue_in : CH_W'(0),
                        mode_reg ? green_in : CH_W'(0),
                        red_or_gray};

    // which centres this pixel completes, one bit per job_t code
    always_comb
    begin
        in_mask[JOB_UPPER_LEFT] = (row_cnt_reg != '0) && (col_cnt_reg != '0);
        in_mask[JOB_UPPER_EDGE] = (row_cnt_reg != '0) && (col_cnt_reg == last_col);
        in_mask[JOB_LAST_LEFT]  = (row_cnt_reg == last_row) && (col_cnt_reg != '0);
        in_mask[JOB_LAST_EDGE]  = (row_cnt_reg == last_row) && (col_cnt_reg == last_col);
    end

    always_comb
    begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (cfg_hit)
        begin
            col_cnt_next = '0;
            row_cnt_next = '0;
        end
        else if (in_accept)
        begin
            if (col_cnt_reg == last_col)
            begin
                col_cnt_next = '0;
                row_cnt_next = (row_cnt_reg == last_row) ? '0 : row_cnt_reg + ROW_W'(1);
            end
            else
            begin
                col_cnt_next = col_cnt_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
        end
        else
        begin
            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
        end
    end

    // ------------------------------------------------------------ item stage

    bfm_line_buf u_line_buf (
        .clk          (clk),
        .rd_en        (in_accept),
        .rd_addr      (col_cnt_reg),
        .wr_en        (b_retire),
        .wr_addr      (b_col_reg),
        .upper_wdata  (middle_rd),
        .middle_wdata (b_pix_reg),
        .upper_rdata  (upper_rd),
        .middle_rdata (middle_rd)
    );

    assign cur_col = '{top: upper_rd, mid: middle_rd, bot: b_pix_reg};

    // window chain: cur -> previous column -> column before that
    bfm_col_cell u_cell0 (
        .clk     (clk),
        .shift   (b_retire),
        .col_in  (cur_col),
        .col_out (win0)
    );

    bfm_col_cell u_cell1 (
        .clk     (clk),
        .shift   (b_retire),
        .col_in  (win0),
        .col_out (win1)
    );

    assign d_ready     = !d_valid_reg || !out_stall;
    assign c_ready     = !c_valid_reg || d_ready;
    assign b_emit      = b_valid_reg && (b_mask_reg != '0) && c_ready;
    assign b_mask_rest = b_mask_reg & (b_mask_reg - job_mask_t'(1));
    assign b_retire    = b_valid_reg &&
                         ((b_mask_reg == '0) || (b_emit && (b_mask_rest == '0)));
    assign in_stall    = b_valid_reg && !b_retire;

    always_comb
    begin
        if (b_mask_reg[JOB_UPPER_LEFT])
        begin
            b_job = JOB_UPPER_LEFT;
        end
        else if (b_mask_reg[JOB_UPPER_EDGE])
        begin
            b_job = JOB_UPPER_EDGE;
        end
        else if (b_mask_reg[JOB_LAST_LEFT])
        begin
            b_job = JOB_LAST_LEFT;
        end
        else
        begin
            b_job = JOB_LAST_EDGE;
        end
    end

    // on the second row the row above the centre replicates the first row
    assign b_top_is_mid = (b_row_reg == ROW_W'(1));
    // at column one the left neighbour replicates column zero
    assign left_col     = (b_col_reg == COL_W'(1)) ? win0 : win1;

    always_comb
    begin
        ls = '0;
        ms = '0;
        rs = '0;
        for (int ch = 0; ch < NCH; ch++)
        begin
            ls = col_sum(left_col, ch, b_job[1], b_top_is_mid);
            ms = col_sum(win0, ch, b_job[1], b_top_is_mid);
            rs = col_sum(cur_col, ch, b_job[1], b_top_is_mid);
            if ((ch != 0) && (!mode_reg || (ch >= CHANNELS)))
            begin
                b_sum[ch] = '0;
            end
            else if (b_job[0])
            begin
                b_sum[ch] = SUM_W'(ms) + (SUM_W'(rs) << 1);
            end
            else
            begin
                b_sum[ch] = SUM_W'(ls) + SUM_W'(ms) + SUM_W'(rs);
            end
        end
    end

    always_comb
    begin
        b_valid_next = b_valid_reg;
        b_mask_next  = b_mask_reg;
        if (in_accept)
        begin
            b_valid_next = 1'b1;
            b_mask_next  = in_mask;
        end
        else if (b_retire)
        begin
            b_valid_next = 1'b0;
            b_mask_next  = '0;
        end
        else if (b_emit)
        begin
            b_mask_next  = b_mask_rest;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
            b_mask_reg  <= '0;
        end
        else
        begin
            b_valid_reg <= b_valid_next;
            b_mask_reg  <= b_mask_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            b_col_reg <= col_cnt_reg;
            b_row_reg <= row_cnt_reg;
            b_pix_reg <= in_pix;
        end
    end

    // ------------------------------------------------------------- sum stage

    assign c_valid_next = b_emit ? 1'b1 : (d_ready ? 1'b0 : c_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= c_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_emit)
        begin
            for (int ch = 0; ch < NCH; ch++)
            begin
                c_sum_reg[ch] <= b_sum[ch];
            end
            c_row_reg    <= b_job[1] ? b_row_reg : b_row_reg - ROW_W'(1);
            c_col_reg    <= b_job[0] ? b_col_reg : b_col_reg - COL_W'(1);
            c_lrun_reg   <= (b_mask_rest == '0);
            c_lframe_reg <= (b_job == JOB_LAST_EDGE);
        end
    end

    for (genvar g = 0; g < NCH; g++)
    begin : g_mean
        bfm_mean u_mean (
            .sum  (c_sum_reg[g]),
            .mean (c_mean[g])
        );
    end

    // ---------------------------------------------------------- output stage

    assign d_load       = c_valid_reg && d_ready;
    assign d_valid_next = d_load ? 1'b1 : (out_stall ? d_valid_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else
        begin
            d_valid_reg <= d_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_load)
        begin
            for (int ch = 0; ch < NCH; ch++)
            begin
                d_mean_reg[ch] <= c_mean[ch];
            end
            d_row_reg    <= c_row_reg;
            d_col_reg    <= c_col_reg;
            d_lrun_reg   <= c_lrun_reg;
            d_lframe_reg <= c_lframe_reg;
        end
    end

    assign out_valid       = d_valid_reg;
    assign out_red_or_gray = d_mean_reg[0];
    assign out_green       = d_mean_reg[1];
    assign out_blue        = d_mean_reg[2];
    assign out_row         = d_row_reg;
    assign out_column      = d_col_reg;
    assign last_of_run     = d_lrun_reg;
    assign last_of_frame   = d_lframe_reg;

    // ------------------------------------------------------------ assertions

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> b_valid_reg)
        else $error("input stalled with no pixel in the item stage");

    a_frame_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_of_frame) |-> last_of_run)
        else $error("frame end word is not the last of its run");

    a_pending_jobs_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && (b_mask_reg != '0) && !c_ready) |=>
        (b_valid_reg && $stable(b_mask_reg)))
        else $error("pending results lost while the result path was full");

endmodule

// File: tb/tb_box_filter_3x3_mean_top.sv
module tb_box_filter_3x3_mean_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bfm_pkg::*;

    localparam int BOX_AREA = 9;
    localparam int SETTLE_CYCLES = 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam longint TIMEOUT_NS = 5_000_000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] column;
        logic             run_end;
        logic             frame_end;
    } smoothed_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [CH_W-1:0]      red_or_gray = '0;
    logic [CH_W-1:0]      green_in = '0;
    logic [CH_W-1:0]      blue_in = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [CH_W-1:0]      out_red_or_gray;
    logic [CH_W-1:0]      out_green;
    logic [CH_W-1:0]      out_blue;
    logic [ROW_W-1:0]     out_row;
    logic [COL_W-1:0]     out_column;
    logic                 last_of_run;
    logic                 last_of_frame;

    box_filter_3x3_mean_top u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .red_or_gray     (red_or_gray),
        .green_in        (green_in),
        .blue_in         (blue_in),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .out_red_or_gray (out_red_or_gray),
        .out_green       (out_green),
        .out_blue        (out_blue),
        .out_row         (out_row),
        .out_column      (out_column),
        .last_of_run     (last_of_run),
        .last_of_frame   (last_of_frame)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // filter model state
    pix_t                upper_rows [MAX_WIDTH];
    pix_t                middle_rows [MAX_WIDTH];
    col_t                win_c1;
    col_t                win_c2;
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic                rgb_mode;

    smoothed_t   expected_pixels [$];
    smoothed_t   want;
    int unsigned error_count = 0;
    int unsigned pixels_sent = 0;
    int unsigned results_checked = 0;
    int unsigned settings_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned hold_left = 0;

    task automatic restart_frame();
        col_pos = 0;
        row_pos = 0;
        win_c1 = '0;
        win_c2 = '0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        case (index)
            REG_WIDTH:  width_reg = value[WIDTH_W-1:0];
            REG_HEIGHT: height_reg = value[HEIGHT_W-1:0];
            REG_MODE:   rgb_mode = value[0];
            default:    return;
        endcase
        restart_frame();
    endtask

    function automatic pix_t tap_of(input col_t c, input int idx);
        case (idx)
            0:       return c.top;
            1:       return c.mid;
            default: return c.bot;
        endcase
    endfunction

    function automatic smoothed_t window_mean(input col_t lc, input col_t mc, input col_t rc,
                                              input int t, input int m, input int b,
                                              input int unsigned row, input int unsigned col,
                                              input logic frame_end);
        pix_t        taps [9];
        int unsigned sum [3];
        int unsigned nch;
        smoothed_t   res;
        nch = rgb_mode ? CHANNELS : 1;
        taps[0] = tap_of(lc, t);
        taps[1] = tap_of(mc, t);
        taps[2] = tap_of(rc, t);
        taps[3] = tap_of(lc, m);
        taps[4] = tap_of(mc, m);
        taps[5] = tap_of(rc, m);
        taps[6] = tap_of(lc, b);
        taps[7] = tap_of(mc, b);
        taps[8] = tap_of(rc, b);
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = 0;
            if (ch < nch)
            begin
                for (int k = 0; k < 9; k++)
                    sum[ch] += taps[k][ch*CH_W +: CH_W];
                sum[ch] = sum[ch] / BOX_AREA;
            end
        end
        res.red = sum[0][CH_W-1:0];
        res.green = sum[1][CH_W-1:0];
        res.blue = sum[2][CH_W-1:0];
        res.row = row[ROW_W-1:0];
        res.column = col[COL_W-1:0];
        res.run_end = 1'b0;
        res.frame_end = frame_end;
        return res;
    endfunction

    // work out the results one accepted pixel causes and advance the model
    task automatic predict_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                                 input logic [CH_W-1:0] b);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned rr;
        int          top;
        int          n;
        pix_t        px;
        col_t        cur;
        col_t        left;
        smoothed_t   found [4];
        w = width_reg;
        if (w < 2)
            w = 2;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        h = height_reg;
        if (h < 2)
            h = 2;
        if (col_pos >= w)
            col_pos = 0;
        if (row_pos >= h)
            row_pos = 0;
        c = col_pos;
        rr = row_pos;
        n = 0;
        px = rgb_mode ? {b, g, r} : {16'h0000, r};
        cur.top = upper_rows[c];
        cur.mid = middle_rows[c];
        cur.bot = px;
        left = (c == 1) ? win_c1 : win_c2;
        top = (rr == 1) ? 1 : 0;
        if (rr >= 1)
        begin
            if (c >= 1)
            begin
                found[n] = window_mean(left, win_c1, cur, top, 1, 2, rr - 1, c - 1, 1'b0);
                n++;
            end
            if (c == w - 1)
            begin
                found[n] = window_mean(win_c1, cur, cur, top, 1, 2, rr - 1, c, 1'b0);
                n++;
            end
        end
        // last row: its own results come interleaved with those of the row above
        if (rr == h - 1)
        begin
            if (c >= 1)
            begin
                found[n] = window_mean(left, win_c1, cur, 1, 2, 2, rr, c - 1, 1'b0);
                n++;
            end
            if (c == w - 1)
            begin
                found[n] = window_mean(win_c1, cur, cur, 1, 2, 2, rr, c, 1'b1);
                n++;
            end
        end
        if (n > 0)
            found[n-1].run_end = 1'b1;
        for (int i = 0; i < n; i++)
            expected_pixels.push_back(found[i]);
        upper_rows[c] = cur.mid;
        middle_rows[c] = px;
        win_c2 = win_c1;
        win_c1 = cur;
        c++;
        if (c >= w)
        begin
            c = 0;
            rr++;
            if (rr >= h)
                rr = 0;
        end
        col_pos = c;
        row_pos = rr;
    endtask

    function automatic logic [CH_W-1:0] rand_channel();
        case ($urandom_range(7))
            0:       return 8'h00;
            1:       return 8'hff;
            default: return CH_W'($urandom_range(255));
        endcase
    endfunction

    // called and returns at a falling edge
    task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                              input logic [CH_W-1:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red_or_gray <= r;
        green_in <= g;
        blue_in <= b;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_pixel(r, g, b);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic send_pixels(input int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_pixel(rand_channel(), rand_channel(), rand_channel());
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        apply_register(index, value);
        settings_count++;
        @(negedge clk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input logic mode);
        write_register(REG_WIDTH, w);
        write_register(REG_HEIGHT, h);
        write_register(REG_MODE, {15'd0, mode});
    endtask

    // sender holds off until every expected word is out, then the pipe settles
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_pixels.size() != 0 || hold_left != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_idling(input int unsigned send_pct, input int unsigned recv_pct);
        send_idle_pct = send_pct;
        stall_pct = recv_pct;
    endtask

    task automatic test_gray_extremes();
        set_idling(0, 0);
        set_frame(16'd3, 16'd3, 1'b0);
        // green and blue carry junk that gray mode must ignore
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2 == 0) ? 8'hff : 8'h00, 8'hff, 8'hff);
        drain_results();
    endtask

    task automatic test_rgb_clamped_corners();
        set_idling(0, 0);
        // width and height below the minimum clamp to two
        write_register(REG_WIDTH, 16'd0);
        write_register(REG_HEIGHT, 16'd1);
        write_register(REG_MODE, 16'd1);
        write_register(REG_UNUSED, CFG_W'($urandom_range(65535)));
        for (int i = 0; i < 4; i++)
            send_pixel(8'hff, 8'h00, (i % 2 == 0) ? 8'hff : 8'h00);
        drain_results();
        set_frame(16'd3, 16'd2, 1'b1);
        send_pixel(8'h00, 8'hff, 8'h00);
        send_pixel(8'hff, 8'hff, 8'hff);
        send_pixel(8'h00, 8'h00, 8'h00);
        send_pixel(8'hff, 8'h00, 8'h80);
        send_pixel(8'h01, 8'hfe, 8'h7f);
        send_pixel(8'h80, 8'h40, 8'h20);
        drain_results();
    endtask

    task automatic test_random_frames();
        int unsigned phase_sent;
        int unsigned w;
        int unsigned h;
        int unsigned frame_px;
        int unsigned count;
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       set_idling(0, 0);
                1:       set_idling(50, 0);
                2:       set_idling(0, 50);
                default: set_idling(8, 8);
            endcase
            phase_sent = 0;
            while (phase_sent < 32)
            begin
                w = $urandom_range(2, 9);
                h = $urandom_range(2, 6);
                drain_results();
                set_frame(CFG_W'(w), CFG_W'(h), 1'($urandom_range(1)));
                frame_px = w * h;
                case ($urandom_range(4))
                    0:       count = $urandom_range(1, frame_px - 1);  // cut short by a restart
                    1:       count = 2 * frame_px;                     // frame wraps into the next
                    default: count = frame_px;
                endcase
                send_pixels(count);
                phase_sent += count;
            end
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        set_idling(0, 0);
        set_frame(16'd4, 16'd12, 1'b1);
        hold_left = HOLD_OFF_CYCLES;
        send_pixels(24);
        // sender pauses mid frame until everything owed has come
        drain_results();
        send_pixels(24);
        drain_results();
    endtask

    task automatic test_widest_frame();
        set_idling(8, 8);
        // 2047 clamps to the full line length; a stretch of the first row completes no window
        set_frame(16'd2047, 16'd2, 1'b1);
        send_pixels(24);
        drain_results();
    endtask

    task automatic test_tallest_frame();
        set_idling(0, 0);
        set_frame(16'd2, 16'hffff, 1'b0);
        send_pixels(40);
        drain_results();
    endtask

    // receiver side: random stalls plus an occasional long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic check_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
        if (act_v !== exp_v)
        begin
            error_count++;
            $display("%0t: %s mismatch at row %0d col %0d, expected %0d, actual %0d",
                     $time, name, want.row, want.column, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0)
        begin
            if (expected_pixels.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected word, expected none, actual row %0d col %0d",
                         $time, out_row, out_column);
            end
            else
            begin
                want = expected_pixels.pop_front();
                check_field("out_red_or_gray", 16'(want.red), 16'(out_red_or_gray));
                check_field("out_green", 16'(want.green), 16'(out_green));
                check_field("out_blue", 16'(want.blue), 16'(out_blue));
                check_field("out_row", want.row, out_row);
                check_field("out_column", 16'(want.column), 16'(out_column));
                check_field("last_of_run", 16'(want.run_end), 16'(last_of_run));
                check_field("last_of_frame", 16'(want.frame_end), 16'(last_of_frame));
                results_checked++;
            end
        end
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("%0t: timeout with %0d words still owed", $time, expected_pixels.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < MAX_WIDTH; i++)
        begin
            upper_rows[i] = '0;
            middle_rows[i] = '0;
        end
        width_reg = WIDTH_RESET;
        height_reg = HEIGHT_RESET;
        rgb_mode = 1'b0;
        restart_frame();
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_gray_extremes();
        test_rgb_clamped_corners();
        test_random_frames();
        test_backpressure();
        test_widest_frame();
        test_tallest_frame();

        drain_results();
        $display("run covered %0d pixels over %0d register writes, gray and rgb, widths 2 to %0d",
                 pixels_sent, settings_count, MAX_WIDTH);
        $display("%0d smoothed words checked, %0d mismatches", results_checked, error_count);
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
